/* sv/bm3_pkg.sv */
`timescale 1ns / 1ps
// Package for the 3x3 mosaic block: sizes, payload structs, register codes
// and the small arithmetic helpers. No dependencies.
package bm3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int TILE_SIZE    = 3;
    localparam int TILE_DEPTH   = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TILE_AW      = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
    localparam int COORD_LIMIT  = 2048;
    localparam int EFF_MAX_W    = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

    localparam int CFG_W        = 12;
    localparam int CFG_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int COORD_W      = 11;
    localparam int CH_W         = 8;
    localparam int SUM_W        = 12;
    localparam int ENTRY_W      = 3 * SUM_W;
    localparam int M3_W         = 2;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;
    localparam logic [M3_W-1:0]  TILE_LAST    = M3_W'(TILE_SIZE - 1);

    // floor(s / 9) for s < 4096 as (s * 3641) >> 15
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = 24;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CH_W-1:0]    red_out;
        logic [CH_W-1:0]    green_out;
        logic [CH_W-1:0]    blue_out;
        logic               run_last;
    } t_pix_out;

    // block = 1: x/y is the top-left corner of a closed 3x3 block
    typedef struct packed {
        logic               block;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
    } t_emit_req;

    function automatic logic [M3_W-1:0] inc_m3(input logic [M3_W-1:0] m);
        return (m == TILE_LAST) ? '0 : m + M3_W'(1);
    endfunction

    function automatic logic [CH_W-1:0] mean9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        logic [PROD_W-DIV9_SHIFT-1:0] q;
        p = PROD_W'(s) * PROD_W'(DIV9_MUL);
        q = p[PROD_W-1:DIV9_SHIFT];
        return (q > (PROD_W-DIV9_SHIFT)'(255)) ? {CH_W{1'b1}} : q[CH_W-1:0];
    endfunction

endpackage

/* sv/bm3_cfg.sv */
`timescale 1ns / 1ps
// APB register file: image width and height, plus their clamped values.
// Depends on bm3_pkg.
module bm3_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bm3_pkg::CFG_AW-1:0]  paddr,
    input  logic [bm3_pkg::APB_DW-1:0]  pwdata,
    output logic [bm3_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bm3_pkg::CFG_W-1:0]   o_width,
    output logic [bm3_pkg::CFG_W-1:0]   o_height
);
    import bm3_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    t_reg_idx         reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width < MIN_DIM) begin
            o_width = MIN_DIM;
        end else if (r_width > CFG_W'(EFF_MAX_W)) begin
            o_width = CFG_W'(EFF_MAX_W);
        end else begin
            o_width = r_width;
        end
        if (r_height < MIN_DIM) begin
            o_height = MIN_DIM;
        end else if (r_height > CFG_W'(COORD_LIMIT)) begin
            o_height = CFG_W'(COORD_LIMIT);
        end else begin
            o_height = r_height;
        end
    end

endmodule

/* sv/bm3_acc.sv */
`timescale 1ns / 1ps
// Raster counters, input register and per-tile running sums (tile memory
// with read-modify-write bypass). Hands closed blocks and leftover pixels on.
// Depends on bm3_pkg.
module bm3_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bm3_pkg::t_pix_in           i_data,
    output logic                       o_stall,
    input  logic [bm3_pkg::CFG_W-1:0]  i_width,
    input  logic [bm3_pkg::CFG_W-1:0]  i_height,
    output logic                       o_req_valid,
    output bm3_pkg::t_emit_req         o_req,
    input  logic                       i_req_free
);
    import bm3_pkg::*;

    // raster position of the next pixel
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [M3_W-1:0]    r_col_m3, n_col_m3;
    logic [M3_W-1:0]    r_row_m3, n_row_m3;
    logic [TILE_AW-1:0] r_tile, n_tile;

    // input stage
    logic               r_b_valid;
    t_pix_in            r_b_pix;
    logic [COORD_W-1:0] r_b_x;
    logic [COORD_W-1:0] r_b_y;
    logic               r_b_tile;
    logic               r_b_first;
    logic               r_b_close;
    logic [TILE_AW-1:0] r_b_idx;
    logic [ENTRY_W-1:0] r_b_rd;
    logic               r_b_byp;
    logic [ENTRY_W-1:0] r_b_byp_e;

    logic [ENTRY_W-1:0] r_mem [TILE_DEPTH];

    logic               accept;
    logic               wrap0, wrap1;
    logic [CFG_W-1:0]   y1;
    logic [M3_W-1:0]    ym1;
    logic [COORD_W-1:0] cur_x, cur_y;
    logic [M3_W-1:0]    cur_xm, cur_ym;
    logic [TILE_AW-1:0] cur_tile;
    logic               cur_in_tile;
    logic [CFG_W-1:0]   nx, ny;

    logic               b_needs, b_go, mem_we;
    logic [ENTRY_W-1:0] b_base, b_px, b_e;

    // start-of-step wrap (only after a register change) and step advance
    always_comb begin
        wrap0    = {1'b0, r_col} >= i_width;
        y1       = wrap0 ? ({1'b0, r_row} + CFG_W'(1)) : {1'b0, r_row};
        ym1      = wrap0 ? inc_m3(r_row_m3) : r_row_m3;
        wrap1    = y1 >= i_height;
        cur_x    = wrap0 ? '0 : r_col;
        cur_xm   = wrap0 ? '0 : r_col_m3;
        cur_tile = wrap0 ? '0 : r_tile;
        cur_y    = wrap1 ? '0 : y1[COORD_W-1:0];
        cur_ym   = wrap1 ? '0 : ym1;

        cur_in_tile = (({1'b0, cur_x} + CFG_W'(TILE_LAST) - CFG_W'(cur_xm)) < i_width)
                   && (({1'b0, cur_y} + CFG_W'(TILE_LAST) - CFG_W'(cur_ym)) < i_height);

        nx = {1'b0, cur_x} + CFG_W'(1);
        ny = {1'b0, cur_y} + CFG_W'(1);
        if (nx >= i_width) begin
            n_col    = '0;
            n_col_m3 = '0;
            n_tile   = '0;
            if (ny >= i_height) begin
                n_row    = '0;
                n_row_m3 = '0;
            end else begin
                n_row    = ny[COORD_W-1:0];
                n_row_m3 = inc_m3(cur_ym);
            end
        end else begin
            n_col    = nx[COORD_W-1:0];
            n_col_m3 = inc_m3(cur_xm);
            n_tile   = (cur_xm == TILE_LAST) ? cur_tile + TILE_AW'(1) : cur_tile;
            n_row    = cur_y;
            n_row_m3 = cur_ym;
        end
    end

    always_comb begin
        b_needs = !r_b_tile || r_b_close;
        b_go    = r_b_valid && (!b_needs || i_req_free);
        mem_we  = b_go && r_b_tile;
        o_stall = r_b_valid && !b_go;
        accept  = i_valid && !o_stall;

        b_base = r_b_byp ? r_b_byp_e : r_b_rd;
        b_px   = {4'b0, r_b_pix.blue_in, 4'b0, r_b_pix.green_in, 4'b0, r_b_pix.red_in};
        if (r_b_first) begin
            b_e = b_px;
        end else begin
            b_e[SUM_W-1:0]         = b_base[SUM_W-1:0] + b_px[SUM_W-1:0];
            b_e[2*SUM_W-1:SUM_W]   = b_base[2*SUM_W-1:SUM_W] + b_px[2*SUM_W-1:SUM_W];
            b_e[3*SUM_W-1:2*SUM_W] = b_base[3*SUM_W-1:2*SUM_W] + b_px[3*SUM_W-1:2*SUM_W];
        end

        o_req_valid = r_b_valid && b_needs;
        o_req.block = r_b_tile;
        if (r_b_tile) begin
            o_req.x = r_b_x - COORD_W'(TILE_LAST);
            o_req.y = r_b_y - COORD_W'(TILE_LAST);
            o_req.r = mean9(b_e[SUM_W-1:0]);
            o_req.g = mean9(b_e[2*SUM_W-1:SUM_W]);
            o_req.b = mean9(b_e[3*SUM_W-1:2*SUM_W]);
        end else begin
            o_req.x = r_b_x;
            o_req.y = r_b_y;
            o_req.r = r_b_pix.red_in;
            o_req.g = r_b_pix.green_in;
            o_req.b = r_b_pix.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_m3  <= '0;
            r_row_m3  <= '0;
            r_tile    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_col_m3 <= n_col_m3;
                r_row_m3 <= n_row_m3;
                r_tile   <= n_tile;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix   <= i_data;
            r_b_x     <= cur_x;
            r_b_y     <= cur_y;
            r_b_tile  <= cur_in_tile;
            r_b_first <= (cur_xm == '0) && (cur_ym == '0);
            r_b_close <= (cur_xm == TILE_LAST) && (cur_ym == TILE_LAST);
            r_b_idx   <= cur_tile;
            r_b_byp   <= mem_we && (r_b_idx == cur_tile);
            r_b_byp_e <= b_e;
        end
    end

    // tile sums: written as the stage retires, read when the next pixel lands
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_b_idx] <= b_e;
        end
        if (accept) begin
            r_b_rd <= r_mem[cur_tile];
        end
    end

    a_m3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_m3 <= TILE_LAST) && (r_row_m3 <= TILE_LAST))
        else $error("phase counter out of range");

    a_tile_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} == CFG_W'(r_tile) * CFG_W'(TILE_SIZE) + CFG_W'(r_col_m3))
        else $error("tile index out of step with column");

endmodule

/* sv/bm3_emit.sv */
`timescale 1ns / 1ps
// Output register and sequencer: one result for a leftover pixel, nine in
// raster order for a closed block. Depends on bm3_pkg.
module bm3_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  bm3_pkg::t_emit_req i_req,
    output logic               o_req_free,
    output logic               o_valid,
    output bm3_pkg::t_pix_out  o_data,
    input  logic               i_stall
);
    import bm3_pkg::*;

    logic               r_c_valid;
    logic               r_c_block;
    logic               r_c_last;
    logic [COORD_W-1:0] r_c_x0;
    logic [COORD_W-1:0] r_c_x;
    logic [COORD_W-1:0] r_c_y;
    logic [M3_W-1:0]    r_c_dx;
    logic [M3_W-1:0]    r_c_dy;
    logic [CH_W-1:0]    r_c_r;
    logic [CH_W-1:0]    r_c_g;
    logic [CH_W-1:0]    r_c_b;

    logic               out_go;
    logic               load;

    assign out_go     = r_c_valid && !i_stall;
    assign o_req_free = !r_c_valid || (out_go && r_c_last);
    assign load       = i_req_valid && o_req_free;

    assign o_valid          = r_c_valid;
    assign o_data.pos_x     = r_c_x;
    assign o_data.pos_y     = r_c_y;
    assign o_data.red_out   = r_c_r;
    assign o_data.green_out = r_c_g;
    assign o_data.blue_out  = r_c_b;
    assign o_data.run_last  = r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (load) begin
            r_c_valid <= 1'b1;
        end else if (out_go && r_c_last) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_c_block <= i_req.block;
            r_c_last  <= !i_req.block;
            r_c_x0    <= i_req.x;
            r_c_x     <= i_req.x;
            r_c_y     <= i_req.y;
            r_c_dx    <= '0;
            r_c_dy    <= '0;
            r_c_r     <= i_req.r;
            r_c_g     <= i_req.g;
            r_c_b     <= i_req.b;
        end else if (out_go && !r_c_last) begin
            if (r_c_dx == TILE_LAST) begin
                r_c_dx <= '0;
                r_c_x  <= r_c_x0;
                r_c_dy <= r_c_dy + M3_W'(1);
                r_c_y  <= r_c_y + COORD_W'(1);
            end else begin
                r_c_dx <= r_c_dx + M3_W'(1);
                r_c_x  <= r_c_x + COORD_W'(1);
            end
            r_c_last <= (r_c_dy == TILE_LAST) && (r_c_dx == TILE_LAST - M3_W'(1));
        end
    end

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !r_c_block |-> r_c_last)
        else $error("pass-through result not marked last");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.run_last |=> o_valid)
        else $error("block run broken off before its last result");

    a_block_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_block |-> (r_c_x - r_c_x0) <= COORD_W'(TILE_LAST))
        else $error("block column outside its tile");

endmodule

/* sv/block_mosaic_3x3.sv */
`timescale 1ns / 1ps
// 3x3 mosaic (pixelation) block, top level.
// Usage:
//   Input channel (i_valid / i_data / o_stall) takes RGB pixels in raster
//   order. A transfer happens on a rising edge with valid high, stall low.
//   Output channel (o_valid / o_data / i_stall) gives pixels with their
//   coordinates. Pixels inside whole 3x3 tiles come out as the tile mean,
//   all nine in raster order once the tile's bottom-right pixel arrives;
//   leftover right columns and bottom rows come out as they are.
//   Results pass the input register, then the output register.
//   Throughput: one result per cycle while i_stall is low, set by the
//   output register. A non-closing tile pixel gives no result, a
//   pass-through pixel gives one, and a tile-closing pixel gives nine and
//   holds the output register until the ninth is taken.
//   When the receiver stalls, the output holds; pixels that need no result
//   keep flowing, the next one that needs a result waits in the input
//   register and o_stall rises.
//   Reset clears the raster position and both pipeline stages and loads
//   width 640, height 480. Tile sums need no clearing.
//   Write image_width (0x0) and image_height (0x4) only while idle.
// Depends on bm3_pkg, bm3_cfg, bm3_acc, bm3_emit.
module block_mosaic_3x3 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  bm3_pkg::t_pix_in            i_data,
    output logic                        o_stall,
    output logic                        o_valid,
    output bm3_pkg::t_pix_out           o_data,
    input  logic                        i_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bm3_pkg::CFG_AW-1:0]  paddr,
    input  logic [bm3_pkg::APB_DW-1:0]  pwdata,
    output logic [bm3_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bm3_pkg::*;

    logic [CFG_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;
    logic             req_valid;
    t_emit_req        req;
    logic             req_free;

    bm3_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (width_eff),
        .o_height (height_eff)
    );

    bm3_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_free  (req_free)
    );

    bm3_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_free  (req_free),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule
